### src/chained_range_remap_assert.svh
// Assertion macros shared by the remap block.
`ifndef CHAINED_RANGE_REMAP_ASSERT_SVH
`define CHAINED_RANGE_REMAP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("remap block assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CRR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("remap block assertion failed");

`endif

### src/crr_pkg.sv
// Types and constants of the chained range remap block.
package crr_pkg;

    localparam int WORD_W = 32;
    localparam int STAGES = 7;
    localparam int SLOTS = 32;
    localparam int TOTAL_WINDOWS = STAGES * SLOTS;
    localparam int ADDR_W = (TOTAL_WINDOWS > 1) ? $clog2(TOTAL_WINDOWS) : 1;
    localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int SLOT_CNT_W = $clog2(SLOTS + 1);

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_XLATE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [2:0]        stage;
        logic [4:0]        slot;
        logic              window_valid;
        logic [WORD_W-1:0] dest_start;
        logic [WORD_W-1:0] src_start;
        logic [WORD_W-1:0] span;
        logic [WORD_W-1:0] value;
    } crr_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] mapped_value;
        logic [WORD_W-1:0] running_min;
    } crr_out_t;

    typedef struct packed {
        logic [WORD_W-1:0] dest;
        logic [WORD_W-1:0] src;
        logic [WORD_W-1:0] span;
    } crr_window_t;

    typedef enum logic {
        ST_IDLE,
        ST_XLATE
    } crr_state_t;

endpackage

### src/crr_ram.sv
// Generic simple dual-port RAM with a registered read.
module crr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/chained_range_remap.sv
// A write, clear or unused item gives its result in the cycle after it is accepted.
// A translate item reads one window per cycle from the single RAM read port, and reads at
// most STAGES * SLOTS windows (224 at the default sizes) before its result comes.
// The block takes one item at a time; the input is not ready while a translation runs.
// Reset clears the window valid bits and sets the running minimum to all ones.
// Window contents are not cleared, so no clearing pass runs after reset.
`include "chained_range_remap_assert.svh"

module chained_range_remap (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  crr_pkg::crr_in_t  s_word,
    output logic              m_valid,
    input  logic              m_ready,
    output crr_pkg::crr_out_t m_word
);

    import crr_pkg::*;

    crr_state_t state_reg, state_next;

    logic                  valid_reg [TOTAL_WINDOWS];
    logic                  vbit_reg;
    logic                  pend_reg, pend_next;
    logic [STG_W-1:0]      stage_reg, stage_next;
    logic [ADDR_W-1:0]     base_reg, base_next;
    logic [SLOT_CNT_W-1:0] issue_slot_reg, issue_slot_next;
    logic [WORD_W-1:0]     value_reg, value_next;
    logic [WORD_W-1:0]     min_reg, min_next;
    logic                  out_valid_reg, out_valid_next;
    crr_out_t              out_word_reg, out_word_next;

    logic                  s_acc;
    logic                  in_range;
    logic                  wr_en;
    logic [ADDR_W+3:0]     wr_lin;
    logic [ADDR_W-1:0]     wr_addr;
    crr_window_t           wr_win;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    crr_window_t           rd_win;
    logic [WORD_W:0]       win_end;
    logic                  hit;
    logic                  stage_end;
    logic                  last_stage;
    logic                  xlate_done;
    logic                  out_load;
    logic [WORD_W-1:0]     v_new;

    assign s_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign s_acc = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_word = out_word_reg;

    assign in_range = (32'(s_word.stage) < 32'(STAGES)) && (32'(s_word.slot) < 32'(SLOTS));
    assign wr_lin = (ADDR_W + 4)'(s_word.stage) * (ADDR_W + 4)'(SLOTS)
                  + (ADDR_W + 4)'(s_word.slot);
    assign wr_addr = wr_lin[ADDR_W-1:0];
    assign wr_en = s_acc && (s_word.action == ACT_WRITE) && in_range;
    assign wr_win = '{dest: s_word.dest_start, src: s_word.src_start, span: s_word.span};

    crr_ram #(
        .WIDTH($bits(crr_window_t)),
        .DEPTH(TOTAL_WINDOWS)
    ) u_win_ram (
        .clk    (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_win),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_win)
    );

    assign win_end = {1'b0, rd_win.src} + {1'b0, rd_win.span};
    assign hit = pend_reg && vbit_reg && (value_reg >= rd_win.src)
               && ({1'b0, value_reg} < win_end);
    assign v_new = hit ? (rd_win.dest + (value_reg - rd_win.src)) : value_reg;
    assign stage_end = pend_reg && (hit || (issue_slot_reg == SLOT_CNT_W'(SLOTS)));
    assign last_stage = (stage_reg == STG_W'(STAGES - 1));
    assign xlate_done = (state_reg == ST_XLATE) && stage_end && last_stage;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_word.action == ACT_XLATE)) begin
                    state_next = ST_XLATE;
                end
            end
            ST_XLATE: begin
                if (xlate_done) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        pend_next = pend_reg;
        stage_next = stage_reg;
        base_next = base_reg;
        issue_slot_next = issue_slot_reg;
        value_next = value_reg;
        min_next = min_reg;
        rd_en = 1'b0;
        rd_addr = '0;
        out_load = 1'b0;
        out_word_next = out_word_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (s_word.action)
                        ACT_XLATE: begin
                            rd_en = 1'b1;
                            rd_addr = '0;
                            pend_next = 1'b1;
                            stage_next = '0;
                            base_next = '0;
                            issue_slot_next = SLOT_CNT_W'(1);
                            value_next = s_word.value;
                        end
                        ACT_CLEAR: begin
                            min_next = '1;
                            out_load = 1'b1;
                            out_word_next = '{mapped_value: '0, running_min: '1};
                        end
                        default: begin
                            out_load = 1'b1;
                            out_word_next = '{mapped_value: '0, running_min: min_reg};
                        end
                    endcase
                end
            end
            ST_XLATE: begin
                if (stage_end) begin
                    value_next = v_new;
                    if (last_stage) begin
                        pend_next = 1'b0;
                        min_next = (v_new < min_reg) ? v_new : min_reg;
                        out_load = 1'b1;
                        out_word_next = '{mapped_value: v_new,
                                          running_min: (v_new < min_reg) ? v_new : min_reg};
                    end else begin
                        rd_en = 1'b1;
                        rd_addr = base_reg + ADDR_W'(SLOTS);
                        pend_next = 1'b1;
                        stage_next = stage_reg + STG_W'(1);
                        base_next = base_reg + ADDR_W'(SLOTS);
                        issue_slot_next = SLOT_CNT_W'(1);
                    end
                end else if (issue_slot_reg < SLOT_CNT_W'(SLOTS)) begin
                    rd_en = 1'b1;
                    rd_addr = base_reg + ADDR_W'(issue_slot_reg);
                    pend_next = 1'b1;
                    issue_slot_next = issue_slot_reg + SLOT_CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                end
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            min_reg <= '1;
            for (int i = 0; i < TOTAL_WINDOWS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            pend_reg <= pend_next;
            out_valid_reg <= out_valid_next;
            min_reg <= min_next;
            if (wr_en) begin
                valid_reg[wr_addr] <= s_word.window_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg <= stage_next;
        base_reg <= base_next;
        issue_slot_reg <= issue_slot_next;
        value_reg <= value_next;
        out_word_reg <= out_word_next;
        if (rd_en) begin
            vbit_reg <= valid_reg[rd_addr];
        end
    end

    `CRR_ASSERT_SAME(a_busy_not_ready, aclk, aresetn, state_reg == ST_XLATE, !s_ready)
    `CRR_ASSERT_SAME(a_done_into_empty, aclk, aresetn, xlate_done, !out_valid_reg)
    `CRR_ASSERT_NEXT(a_xlate_starts_read, aclk, aresetn, s_acc && (s_word.action == ACT_XLATE), (state_reg == ST_XLATE) && pend_reg)
    `CRR_ASSERT_SAME(a_xlate_keeps_reading, aclk, aresetn, (state_reg == ST_XLATE) && !xlate_done, pend_next)

endmodule
